>>> rtl/core/lcq_pkg.sv
// ----------------------------------------------------------------------------
// lcq_pkg
// Shared codes and types for the line command queue.
// ----------------------------------------------------------------------------
package lcq_pkg;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_COPY    = 4'b0010,
		ST_RD_LEN  = 4'b0100,
		ST_RD_CHAR = 4'b1000
	} state_t;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic [7:0] READ_LIMIT_RESET = 8'd20;

endpackage

>>> rtl/core/lcq_ram.sv
// ----------------------------------------------------------------------------
// lcq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lcq_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/line_command_queue.sv
// ----------------------------------------------------------------------------
// line_command_queue
// Gathers received bytes into CR/LF terminated lines and queues whole lines.
// ----------------------------------------------------------------------------
// usage:
//   command channel: kind and rx_byte are taken at a clock edge with start
//   high and busy low. kind byte stores one character, or on CR/LF queues the
//   gathered line; kind read pops the oldest line; kind clear empties all.
//   config channel: cfg_data is written to read_limit when cfg_valid and
//   cfg_ready are high; cfg_ready is always high.
//   results: has_command, char_valid, char_value and last are shown for one
//   cycle with result_valid high; the receiver cannot stall them.
// timing:
//   an ordinary byte or a clear leaves busy low. a terminator that queues a
//   line copies it from the assembly RAM into the line RAM, one character a
//   cycle, with busy high until the last character is written. a read on an
//   empty ring or with read_limit 0 gives its result in the cycle after the
//   request; otherwise the length is read first, then one character per cycle
//   is shown. both RAMs have a registered read port.
// reset: ring and assembler empty, read_limit 20; RAM contents are only read
//   where written since, so no clearing pass runs.
// ----------------------------------------------------------------------------
module line_command_queue #(
	parameter int LINE_MAX    = 20,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] kind,
	input  logic [7:0] rx_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output logic       result_valid,
	output logic       has_command,
	output logic       char_valid,
	output logic [7:0] char_value,
	output logic       last
);

	localparam int CHARS = LINE_MAX - 1;
	localparam int LW    = $clog2(LINE_MAX);
	localparam int AAW   = (CHARS > 1) ? $clog2(CHARS) : 1;
	localparam int SW    = $clog2(QUEUE_DEPTH);
	localparam int HW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SD    = QUEUE_DEPTH * LINE_MAX;
	localparam int SAW   = $clog2(SD);

	lcq_pkg::state_t state_q;

	logic [LW-1:0]  alen_q;
	logic [SW-1:0]  rslot_q;
	logic [SW-1:0]  wslot_q;
	logic [HW-1:0]  held_q;
	logic [7:0]     read_limit_q;
	logic [LW-1:0]  cp_cnt_q;
	logic           wr_pend_s1;
	logic [LW-1:0]  wr_idx_s1;
	logic [SAW-1:0] rbase_q;
	logic [LW-1:0]  n_q;
	logic [LW-1:0]  chr_cnt_q;

	logic           result_valid_q;
	logic           has_command_q;
	logic           char_valid_q;
	logic [7:0]     char_value_q;
	logic           last_q;

	logic           asm_we;
	logic [AAW-1:0] asm_waddr;
	logic           asm_re;
	logic [AAW-1:0] asm_raddr;
	logic [7:0]     asm_rdata;

	logic           st_we;
	logic [SAW-1:0] st_waddr;
	logic [7:0]     st_wdata;
	logic           st_re;
	logic [SAW-1:0] st_raddr;
	logic [7:0]     st_rdata;

	logic           accept;
	logic           is_term;
	logic           can_queue;
	logic           can_pop;
	logic           last_slot_r;
	logic           last_slot_w;
	logic [SAW-1:0] wbase;
	logic [SAW-1:0] rbase;
	logic [7:0]     len_clamp;
	logic [7:0]     limit_m1;
	logic [7:0]     n_calc;

	assign busy      = (state_q != lcq_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	assign is_term     = (rx_byte == lcq_pkg::CHAR_CR) || (rx_byte == lcq_pkg::CHAR_LF);
	assign can_queue   = (alen_q != '0) && (held_q != HW'(QUEUE_DEPTH));
	assign can_pop     = (held_q != '0) && (read_limit_q != 8'd0);
	assign last_slot_r = (rslot_q == SW'(QUEUE_DEPTH - 1));
	assign last_slot_w = (wslot_q == SW'(QUEUE_DEPTH - 1));
	assign wbase       = SAW'(wslot_q) * SAW'(LINE_MAX);
	assign rbase       = SAW'(rslot_q) * SAW'(LINE_MAX);

	// slot layout: entry 0 holds the length, entries 1.. the characters
	assign len_clamp = (st_rdata > 8'(CHARS)) ? 8'(CHARS) : st_rdata;
	assign limit_m1  = read_limit_q - 8'd1;
	assign n_calc    = (limit_m1 < len_clamp) ? limit_m1 : len_clamp;

	always_comb begin
		asm_we    = 1'b0;
		asm_waddr = alen_q[AAW-1:0];
		asm_re    = 1'b0;
		asm_raddr = '0;
		st_we     = 1'b0;
		st_waddr  = wbase;
		st_wdata  = 8'(alen_q);
		st_re     = 1'b0;
		st_raddr  = rbase;
		case (state_q)
			lcq_pkg::ST_IDLE: begin
				if (accept && kind == lcq_pkg::KIND_BYTE) begin
					if (is_term) begin
						if (can_queue) begin
							st_we  = 1'b1;
							asm_re = 1'b1;
						end
					end else if (alen_q < LW'(CHARS)) begin
						asm_we = 1'b1;
					end
				end else if (accept && kind == lcq_pkg::KIND_READ && can_pop) begin
					st_re = 1'b1;
				end
			end
			lcq_pkg::ST_COPY: begin
				if (wr_pend_s1) begin
					st_we    = 1'b1;
					st_waddr = wbase + SAW'(1) + SAW'(wr_idx_s1);
					st_wdata = asm_rdata;
				end
				if (cp_cnt_q < alen_q) begin
					asm_re    = 1'b1;
					asm_raddr = cp_cnt_q[AAW-1:0];
				end
			end
			lcq_pkg::ST_RD_LEN: begin
				if (n_calc != 8'd0) begin
					st_re    = 1'b1;
					st_raddr = rbase_q + SAW'(1);
				end
			end
			lcq_pkg::ST_RD_CHAR: begin
				if ((chr_cnt_q + LW'(1)) < n_q) begin
					st_re    = 1'b1;
					st_raddr = rbase_q + SAW'(2) + SAW'(chr_cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lcq_pkg::ST_IDLE;
			alen_q         <= '0;
			rslot_q        <= '0;
			wslot_q        <= '0;
			held_q         <= '0;
			read_limit_q   <= lcq_pkg::READ_LIMIT_RESET;
			cp_cnt_q       <= '0;
			wr_pend_s1     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				read_limit_q <= cfg_data;
			end
			case (state_q)
				lcq_pkg::ST_IDLE: begin
					if (accept) begin
						case (kind)
							lcq_pkg::KIND_BYTE: begin
								if (is_term) begin
									if (can_queue) begin
										cp_cnt_q   <= LW'(1);
										wr_pend_s1 <= 1'b1;
										state_q    <= lcq_pkg::ST_COPY;
									end else begin
										alen_q <= '0;
									end
								end else if (alen_q < LW'(CHARS)) begin
									alen_q <= alen_q + LW'(1);
								end else begin
									// line too long: drop it and start over
									alen_q <= '0;
								end
							end
							lcq_pkg::KIND_READ: begin
								if (can_pop) begin
									rslot_q <= last_slot_r ? '0 : rslot_q + SW'(1);
									held_q  <= held_q - HW'(1);
									state_q <= lcq_pkg::ST_RD_LEN;
								end else begin
									result_valid_q <= 1'b1;
								end
							end
							lcq_pkg::KIND_CLEAR: begin
								alen_q  <= '0;
								rslot_q <= '0;
								wslot_q <= '0;
								held_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				lcq_pkg::ST_COPY: begin
					if (cp_cnt_q < alen_q) begin
						cp_cnt_q   <= cp_cnt_q + LW'(1);
						wr_pend_s1 <= 1'b1;
					end else begin
						wr_pend_s1 <= 1'b0;
						if (wr_pend_s1) begin
							wslot_q <= last_slot_w ? '0 : wslot_q + SW'(1);
							held_q  <= held_q + HW'(1);
							alen_q  <= '0;
							state_q <= lcq_pkg::ST_IDLE;
						end
					end
				end
				lcq_pkg::ST_RD_LEN: begin
					if (n_calc == 8'd0) begin
						result_valid_q <= 1'b1;
						state_q        <= lcq_pkg::ST_IDLE;
					end else begin
						state_q <= lcq_pkg::ST_RD_CHAR;
					end
				end
				lcq_pkg::ST_RD_CHAR: begin
					result_valid_q <= 1'b1;
					if ((chr_cnt_q + LW'(1)) == n_q) begin
						state_q <= lcq_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lcq_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload and copy/read bookkeeping, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			lcq_pkg::ST_IDLE: begin
				wr_idx_s1     <= '0;
				rbase_q       <= rbase;
				has_command_q <= 1'b0;
				char_valid_q  <= 1'b0;
				char_value_q  <= 8'd0;
				last_q        <= 1'b1;
			end
			lcq_pkg::ST_COPY: begin
				wr_idx_s1 <= cp_cnt_q;
			end
			lcq_pkg::ST_RD_LEN: begin
				n_q           <= LW'(n_calc);
				chr_cnt_q     <= '0;
				has_command_q <= 1'b1;
				char_valid_q  <= 1'b0;
				char_value_q  <= 8'd0;
				last_q        <= 1'b1;
			end
			lcq_pkg::ST_RD_CHAR: begin
				chr_cnt_q     <= chr_cnt_q + LW'(1);
				has_command_q <= 1'b1;
				char_valid_q  <= 1'b1;
				char_value_q  <= st_rdata;
				last_q        <= ((chr_cnt_q + LW'(1)) == n_q);
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign has_command  = has_command_q;
	assign char_valid   = char_valid_q;
	assign char_value   = char_value_q;
	assign last         = last_q;

	lcq_ram #(
		.WIDTH (8),
		.DEPTH (CHARS),
		.ADDR_W(AAW)
	) u_asm_ram (
		.clk  (clk),
		.we   (asm_we),
		.waddr(asm_waddr),
		.wdata(rx_byte),
		.re   (asm_re),
		.raddr(asm_raddr),
		.rdata(asm_rdata)
	);

	lcq_ram #(
		.WIDTH (8),
		.DEPTH (SD),
		.ADDR_W(SAW)
	) u_line_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_command_queue: bytes, reads, clears and idle
// requests go in through the start/busy handshake in random bursts, and each
// streamed read word is compared with a shadow of the line ring kept here.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LINE_MAX     = 20;
	localparam int QUEUE_DEPTH  = 8;
	localparam int CHARS_MAX    = LINE_MAX - 1;
	localparam int DRAIN_CYCLES = LINE_MAX + 4;
	localparam int STALL_LIMIT  = 2000;
	localparam int PRINT_LIMIT  = 40;

	typedef struct packed {
		logic       has_command;
		logic       char_valid;
		logic [7:0] char_value;
		logic       last;
	} read_word_t;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            start     = 1'b0;
	logic            busy;
	lcq_pkg::kind_t  kind      = lcq_pkg::KIND_BYTE;
	logic [7:0]      rx_byte   = 8'h00;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [7:0]      cfg_data  = 8'h00;
	logic            result_valid;
	logic            has_command;
	logic            char_valid;
	logic [7:0]      char_value;
	logic            last;

	// shadow of the assembler and the line ring
	logic [7:0]  asm_chars [CHARS_MAX];
	int unsigned asm_len = 0;
	logic [7:0]  ring_chars [QUEUE_DEPTH][CHARS_MAX];
	int unsigned ring_len [QUEUE_DEPTH];
	int unsigned rd_slot = 0;
	int unsigned wr_slot = 0;
	int unsigned lines_held = 0;
	logic [7:0]  read_limit_shadow = lcq_pkg::READ_LIMIT_RESET;

	read_word_t  read_words_due [$];
	int unsigned errors = 0;
	int unsigned stall_cycles = 0;
	int unsigned burst_left = 0;

	line_command_queue #(
		.LINE_MAX   (LINE_MAX),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.rx_byte     (rx_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.has_command (has_command),
		.char_valid  (char_valid),
		.char_value  (char_value),
		.last        (last)
	);

	always #4 clk = ~clk;

	// updates the shadow for one accepted request and queues the read words it causes
	task automatic apply_request(input lcq_pkg::kind_t k, input logic [7:0] b);
		int unsigned n;
		case (k)
			lcq_pkg::KIND_BYTE: begin
				if (b == lcq_pkg::CHAR_CR || b == lcq_pkg::CHAR_LF) begin
					if (asm_len != 0 && lines_held < QUEUE_DEPTH) begin
						for (int i = 0; i < asm_len; i++)
							ring_chars[wr_slot][i] = asm_chars[i];
						ring_len[wr_slot] = asm_len;
						wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
						lines_held++;
					end
					asm_len = 0;
				end else if (asm_len < CHARS_MAX) begin
					asm_chars[asm_len] = b;
					asm_len++;
				end else begin
					// overflowing byte is lost and the line starts over
					asm_len = 0;
				end
			end
			lcq_pkg::KIND_CLEAR: begin
				asm_len = 0;
				rd_slot = 0;
				wr_slot = 0;
				lines_held = 0;
			end
			lcq_pkg::KIND_READ: begin
				if (lines_held == 0 || read_limit_shadow == 0) begin
					read_words_due.push_back('{1'b0, 1'b0, 8'h00, 1'b1});
				end else begin
					n = read_limit_shadow - 1;
					if (n > ring_len[rd_slot])
						n = ring_len[rd_slot];
					if (n == 0)
						read_words_due.push_back('{1'b1, 1'b0, 8'h00, 1'b1});
					for (int i = 0; i < n; i++)
						read_words_due.push_back('{1'b1, 1'b1, ring_chars[rd_slot][i],
							(i + 1 == n)});
					rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
					lines_held--;
				end
			end
			default: begin
			end
		endcase
	endtask

	// called at a falling edge; returns at the falling edge after the request is taken
	task automatic send_request(input lcq_pkg::kind_t k, input logic [7:0] b);
		if (burst_left == 0) begin
			start = 1'b0;
			kind = lcq_pkg::kind_t'($urandom_range(0, 3));
			rx_byte = 8'($urandom);
			repeat ($urandom_range(0, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 10);
		end
		burst_left--;
		start = 1'b1;
		kind = k;
		rx_byte = b;
		do @(posedge clk); while (busy !== 1'b0);
		apply_request(k, b);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (read_words_due.size() != 0) @(negedge clk);
		// a terminator may still be copying its line
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_read_limit(input logic [7:0] v);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		read_limit_shadow = v;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = 8'($urandom);
	endtask

	task automatic test_empty_queue();
		send_request(lcq_pkg::KIND_READ, 8'hFF);
		send_request(lcq_pkg::KIND_NONE, 8'h5A);
		send_request(lcq_pkg::KIND_CLEAR, 8'hA5);
		send_request(lcq_pkg::KIND_BYTE, lcq_pkg::CHAR_CR);
		send_request(lcq_pkg::KIND_BYTE, lcq_pkg::CHAR_LF);
		send_request(lcq_pkg::KIND_READ, 8'h00);
	endtask

	task automatic test_line_forms();
		// zero and all-ones bytes are ordinary characters
		send_request(lcq_pkg::KIND_BYTE, 8'h00);
		send_request(lcq_pkg::KIND_BYTE, 8'hFF);
		send_request(lcq_pkg::KIND_BYTE, 8'h41);
		send_request(lcq_pkg::KIND_BYTE, lcq_pkg::CHAR_LF);
		send_request(lcq_pkg::KIND_BYTE, 8'h7F);
		send_request(lcq_pkg::KIND_BYTE, 8'h80);
		send_request(lcq_pkg::KIND_BYTE, lcq_pkg::CHAR_CR);
		send_request(lcq_pkg::KIND_READ, 8'h00);
		send_request(lcq_pkg::KIND_READ, 8'h00);
		send_request(lcq_pkg::KIND_READ, 8'h00);
	endtask

	task automatic test_random_traffic(input logic [7:0] limit, input int unsigned quota);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		logic [7:0]  b;
		set_read_limit(limit);
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// well-formed line, some at full length and some overflowing
				pick = $urandom_range(0, 9);
				len = (pick < 7) ? $urandom_range(1, 6) :
					(pick < 9) ? $urandom_range(17, CHARS_MAX) :
					$urandom_range(LINE_MAX, LINE_MAX + 3);
				repeat (len) begin
					do b = 8'($urandom); while (b == lcq_pkg::CHAR_CR || b == lcq_pkg::CHAR_LF);
					send_request(lcq_pkg::KIND_BYTE, b);
				end
				send_request(lcq_pkg::KIND_BYTE,
					$urandom_range(0, 1) ? lcq_pkg::CHAR_CR : lcq_pkg::CHAR_LF);
				sent += len + 1;
			end else if (pick < 85) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, QUEUE_DEPTH + 1) : 1;
				repeat (len) send_request(lcq_pkg::KIND_READ, 8'($urandom));
				sent += len;
			end else if (pick < 95) begin
				b = 8'($urandom);
				if ($urandom_range(0, 3) == 0)
					b = $urandom_range(0, 1) ? lcq_pkg::CHAR_CR : lcq_pkg::CHAR_LF;
				send_request(lcq_pkg::KIND_BYTE, b);
				sent++;
			end else if (pick < 97) begin
				send_request(lcq_pkg::KIND_CLEAR, 8'($urandom));
				sent++;
			end else begin
				// ignored by the block, not counted
				send_request(lcq_pkg::KIND_NONE, 8'($urandom));
			end
		end
	endtask

	always @(posedge clk) begin
		read_word_t got;
		read_word_t want;
		if (arst_n && result_valid) begin
			got = '{has_command, char_valid, char_value, last};
			if (read_words_due.size() == 0) begin
				if (errors < PRINT_LIMIT)
					$display("%0t: unexpected read word has=%0b valid=%0b char=%02h last=%0b",
						$time, got.has_command, got.char_valid, got.char_value, got.last);
				errors++;
			end else begin
				want = read_words_due.pop_front();
				if (got !== want) begin
					if (errors < PRINT_LIMIT)
						$display({"%0t: read word mismatch: expected has=%0b valid=%0b ",
							"char=%02h last=%0b, got has=%0b valid=%0b char=%02h last=%0b"},
							$time, want.has_command, want.char_valid, want.char_value,
							want.last, got.has_command, got.char_valid, got.char_value,
							got.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_empty_queue();
		test_line_forms();
		test_random_traffic(8'd0, 30);
		test_random_traffic(8'd1, 30);
		test_random_traffic(8'd2, 40);
		test_random_traffic(8'd255, 50);
		test_random_traffic(8'($urandom_range(3, 30)), 60);
		test_random_traffic(lcq_pkg::READ_LIMIT_RESET, 65);
		wait_drained();
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/lcq_pkg.sv
rtl/core/lcq_ram.sv
rtl/core/line_command_queue.sv
tb/sv/testbench.sv
